/* rtl/core/bil_pkg.sv */
// ----------------------------------------------------------------------------
// bil_pkg: shared definitions for the bounded indexed list
// Operation codes, status codes, default sizes and the shift control that
// the list controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package bil_pkg;

  // Default sizes of the list.
  localparam int BIL_CAPACITY   = 16;
  localparam int BIL_DATA_WIDTH = 32;

  // Fixed widths of the item fields.
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Operation codes carried by an input item.
  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_INSERT_AT  = 3'd3,
    OP_REMOVE_AT  = 3'd4,
    OP_READ_AT    = 3'd5,
    OP_CLEAR      = 3'd6
  } kind_t;

  // Status codes returned with every result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Shift command broadcast along the chain of cells.
  typedef struct packed {
    logic ins;  // open a gap at the position and load the new value there
    logic rem;  // close the gap at the position
  } shift_ctl_t;

endpackage

/* rtl/core/bil_cell.sv */
// ----------------------------------------------------------------------------
// bil_cell: one storage cell of the list chain
// Holds one element and decides locally whether to hold, load the new
// value, take its lower neighbor (insert) or its upper neighbor (remove).
// ----------------------------------------------------------------------------
module bil_cell #(
  parameter int DATA_WIDTH = bil_pkg::BIL_DATA_WIDTH,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  bil_pkg::shift_ctl_t   ctl,
  input  logic [IDX_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] load_val,
  input  logic [DATA_WIDTH-1:0] lower_val,
  input  logic [DATA_WIDTH-1:0] upper_val,
  output logic [DATA_WIDTH-1:0] q
);
  import bil_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] q_next;

  // Pick the next content from the broadcast command and this cell's place.
  always_comb begin
    priority if (ctl.ins && (pos == MyIdx)) begin
      q_next = load_val;
    end else if (ctl.ins && (MyIdx > pos)) begin
      q_next = lower_val;
    end else if (ctl.rem && (MyIdx >= pos)) begin
      q_next = upper_val;
    end else begin
      q_next = q;
    end
  end

  // Element storage; contents are undefined until written.
  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

/* rtl/core/bounded_indexed_list.sv */
// Result: each accepted item's result item is registered and appears in the cycle after acceptance.
// Throughput: one item per cycle while in_stall is low; every cell of the chain
// shifts, loads or holds together for each accepted item.
// Reset: clears the element count and the output valid; cell contents stay
// undefined until written and are never read before that.
// ----------------------------------------------------------------------------
// bounded_indexed_list: bounded ordered list of signed values
// Push, pop, insert, remove, read and clear on a packed chain of cells, with
// one registered result item (read value, count, status) per input item.
// ----------------------------------------------------------------------------
module bounded_indexed_list #(
  parameter int CAPACITY   = bil_pkg::BIL_CAPACITY,
  parameter int DATA_WIDTH = bil_pkg::BIL_DATA_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bil_pkg::KIND_W-1:0]      kind,
  input  logic signed [bil_pkg::VALUE_W-1:0] item_value,
  input  logic [bil_pkg::POS_W-1:0]       position,
  // Output channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [bil_pkg::VALUE_W-1:0] read_value,
  output logic [bil_pkg::COUNT_W-1:0]     count,
  output logic [bil_pkg::STATUS_W-1:0]    status
);
  import bil_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [DATA_WIDTH-1:0] load_val;
  logic [DATA_WIDTH-1:0] rd_raw;
  logic [VALUE_W-1:0]    rd_wide;

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_next;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] fill_ext;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] op_pos;
  logic             accept;
  logic             full;
  logic             empty;
  logic             do_read;
  shift_ctl_t       op_ctl;
  shift_ctl_t       cell_ctl;
  status_t          st;
  kind_t            op_kind;

  // Handshake: a new item enters whenever the output register is free or
  // is being emptied in the same cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pos_ext  = CMP_W'(position);
  assign fill_ext = CMP_W'(fill_count);
  assign pos_idx  = pos_ext[IDX_W-1:0];
  assign full     = (fill_count == CapCount);
  assign empty    = (fill_count == '0);
  assign op_kind  = kind_t'(kind);

  // Fit the incoming value to the cell width.
  if (DATA_WIDTH <= VALUE_W) begin : g_load_narrow
    assign load_val = item_value[DATA_WIDTH-1:0];
  end else begin : g_load_wide
    assign load_val = {{(DATA_WIDTH - VALUE_W){item_value[VALUE_W-1]}}, item_value};
  end

  // Decode the operation into a shift command, a status and the new count.
  always_comb begin
    op_ctl    = '0;
    op_pos    = pos_idx;
    st        = ST_OK;
    fill_next = fill_count;
    do_read   = 1'b0;
    unique case (op_kind)
      OP_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          op_ctl.ins = 1'b1;
          op_pos     = fill_count[IDX_W-1:0];
          fill_next  = fill_count + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          op_ctl.ins = 1'b1;
          op_pos     = '0;
          fill_next  = fill_count + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st = ST_RANGE;
        end else begin
          op_ctl.rem = 1'b1;
          op_pos     = '0;
          fill_next  = fill_count - CNT_W'(1);
        end
      end
      OP_INSERT_AT: begin
        if (full) begin
          st = ST_FULL;
        end else if (pos_ext > fill_ext) begin
          st = ST_RANGE;
        end else begin
          op_ctl.ins = 1'b1;
          fill_next  = fill_count + CNT_W'(1);
        end
      end
      OP_REMOVE_AT: begin
        if (pos_ext >= fill_ext) begin
          st = ST_RANGE;
        end else begin
          op_ctl.rem = 1'b1;
          fill_next  = fill_count - CNT_W'(1);
        end
      end
      OP_READ_AT: begin
        if (pos_ext >= fill_ext) begin
          st = ST_RANGE;
        end else begin
          do_read = 1'b1;
        end
      end
      OP_CLEAR: begin
        fill_next = '0;
      end
      default: begin
      end
    endcase
  end

  // The chain only moves for an accepted item.
  assign cell_ctl = accept ? op_ctl : '0;

  // Chain of cells; cell 0 is the front of the list.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_val;
    logic [DATA_WIDTH-1:0] upper_val;

    if (g == 0) begin : g_first
      assign lower_val = load_val;
    end else begin : g_lower
      assign lower_val = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign upper_val = cell_q[g];
    end else begin : g_upper
      assign upper_val = cell_q[g+1];
    end

    bil_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX_W     (IDX_W),
      .INDEX     (g)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .pos      (op_pos),
      .load_val (load_val),
      .lower_val(lower_val),
      .upper_val(upper_val),
      .q        (cell_q[g])
    );
  end

  // Read port: the selected cell, sign-extended or cut to the result width.
  assign rd_raw = cell_q[pos_idx];

  if (DATA_WIDTH >= VALUE_W) begin : g_rd_cut
    assign rd_wide = rd_raw[VALUE_W-1:0];
  end else begin : g_rd_ext
    assign rd_wide = {{(VALUE_W - DATA_WIDTH){rd_raw[DATA_WIDTH-1]}}, rd_raw};
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= do_read ? rd_wide : '0;
      count      <= COUNT_W'(fill_next);
      status     <= st;
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bounded indexed list
// A short table of directed items is driven first, followed by random
// phases that fill, drain and scramble the list. A behavioral copy of the
// list predicts each result item that the table does not spell out, and a scoreboard
// compares each one field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import bil_pkg::*;

  localparam int CAP = BIL_CAPACITY;
  localparam int DIRECTED_ROWS = 23;
  localparam int RANDOM_ITEMS = 1600;

  // Kind 7 has no operation behind it; the block must treat it as a no-op.
  localparam logic [KIND_W-1:0] OP_UNUSED = 3'd7;

  // Random phase flavors, each with its own mix of operations.
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_t;

  // Receiver stall flavors.
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  typedef struct {
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;
    status_t                   status;
  } list_result_t;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    bit                        typed;
    list_result_t              res;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [KIND_W-1:0]         kind = '0;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic [POS_W-1:0]          position = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0]        count;
  logic [STATUS_W-1:0]       status;

  bounded_indexed_list uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .item_value(item_value), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .count(count), .status(status)
  );

  // Shadow copy of the list contents and its fill level.
  logic signed [VALUE_W-1:0] shadow_cells [CAP];
  int                        shadow_fill;

  list_result_t pending_results [$];
  stim_row_t    dir_rows [DIRECTED_ROWS];
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           full_seen = 0;
  int           range_seen = 0;
  int           peak_fill = 0;
  int           burst_left = 0;
  int           rx_cycle = 0;
  rx_mode_t     rx_mode = RX_FREE;
  list_result_t rx_exp;

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one operation to the shadow list and return the result it gives.
  function automatic list_result_t apply_list_op(logic [KIND_W-1:0] k,
                                                 logic signed [VALUE_W-1:0] v,
                                                 logic [POS_W-1:0] p);
    list_result_t r;
    int at;
    at = int'(p);
    r.read_value = '0;
    r.status = ST_OK;
    case (k)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (shadow_fill >= CAP) begin
          r.status = ST_FULL;
        end else begin
          if (k == OP_PUSH_BACK) begin
            shadow_cells[shadow_fill] = v;
          end else begin
            for (int i = shadow_fill; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
            shadow_cells[0] = v;
          end
          shadow_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = 0; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_fill--;
        end
      end
      OP_INSERT_AT: begin
        // A full list reports full even when the position is also bad.
        if (shadow_fill >= CAP) begin
          r.status = ST_FULL;
        end else if (at > shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = shadow_fill; i > at; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[at] = v;
          shadow_fill++;
        end
      end
      OP_REMOVE_AT: begin
        if (at >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = at; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_fill--;
        end
      end
      OP_READ_AT: begin
        if (at >= shadow_fill) r.status = ST_RANGE;
        else r.read_value = shadow_cells[at];
      end
      OP_CLEAR: begin
        shadow_fill = 0;
      end
      default: begin
      end
    endcase
    r.count = shadow_fill[COUNT_W-1:0];
    return r;
  endfunction

  // Values lean toward the extremes now and then.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh0000_0000;
      3: return 32'shFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Position that is legal for the operation most of the time.
  function automatic logic [POS_W-1:0] pick_position(logic [KIND_W-1:0] k);
    int hi;
    if ($urandom_range(0, 99) < 15) return POS_W'($urandom_range(0, 15));
    hi = (k == OP_INSERT_AT) ? shadow_fill : shadow_fill - 1;
    if (hi > 15) hi = 15;
    if (hi < 0) hi = 0;
    return POS_W'($urandom_range(0, hi));
  endfunction

  // Choose an operation according to the phase flavor.
  function automatic logic [KIND_W-1:0] pick_kind(phase_t ph);
    int roll;
    roll = $urandom_range(0, 99);
    if (ph == PH_NOISE) return KIND_W'($urandom_range(0, 7));
    if (roll < 2) return OP_CLEAR;
    if (roll < 3) return OP_UNUSED;
    case (ph)
      PH_FILL: begin
        if (roll < 30) return OP_PUSH_BACK;
        if (roll < 55) return OP_PUSH_FRONT;
        if (roll < 80) return OP_INSERT_AT;
        if (roll < 90) return OP_READ_AT;
        return (roll < 95) ? OP_POP_FRONT : OP_REMOVE_AT;
      end
      PH_DRAIN: begin
        if (roll < 35) return OP_POP_FRONT;
        if (roll < 70) return OP_REMOVE_AT;
        if (roll < 85) return OP_READ_AT;
        return (roll < 92) ? OP_PUSH_BACK : OP_INSERT_AT;
      end
      default: begin
        return KIND_W'($urandom_range(0, 5));
      end
    endcase
  endfunction

  // Drive one item, wait for acceptance, record its expected result and
  // then possibly idle before the next item.
  task automatic send_item(input stim_row_t row);
    list_result_t res;
    int gap;
    in_valid <= 1'b1;
    kind <= row.kind;
    item_value <= row.value;
    position <= row.pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = apply_list_op(row.kind, row.value, row.pos);
    if (row.typed) res = row.res;
    pending_results.insert(pending_results.size(), res);
    items_sent++;
    if (res.status == ST_FULL) full_seen++;
    if (res.status == ST_RANGE) range_seen++;
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    // Bursts of back-to-back items separated by idle gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: score each result item, then choose the next stall value.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected (value %0d count %0d status %0d)",
                 $time, read_value, count, status);
        mismatch_count++;
      end else begin
        rx_exp = pending_results[0];
        pending_results.delete(0);
        if (read_value !== rx_exp.read_value) begin
          $display("%0t: read_value expected %0d actual %0d",
                   $time, rx_exp.read_value, read_value);
          mismatch_count++;
        end
        if (count !== rx_exp.count) begin
          $display("%0t: count expected %0d actual %0d", $time, rx_exp.count, count);
          mismatch_count++;
        end
        if (status !== rx_exp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, rx_exp.status, status);
          mismatch_count++;
        end
      end
    end
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 48 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:   out_stall <= 1'b0;
      RX_LIGHT:  out_stall <= ($urandom_range(0, 99) < 25);
      RX_HEAVY:  out_stall <= ($urandom_range(0, 99) < 75);
      default:   out_stall <= rx_cycle[0];
    endcase
  end

  // Stimulus and end of run.
  initial begin
    stim_row_t row;
    phase_t ph;
    int phase_len;
    shadow_fill = 0;
    for (int i = 0; i < CAP; i++) shadow_cells[i] = '0;
    dir_rows = '{
      '{OP_READ_AT,    32'sd0,          4'd0,  1'b1, '{32'sd0, 5'd0, ST_RANGE}},
      '{OP_POP_FRONT,  32'sd0,          4'd0,  1'b1, '{32'sd0, 5'd0, ST_RANGE}},
      '{OP_REMOVE_AT,  32'sd0,          4'd15, 1'b1, '{32'sd0, 5'd0, ST_RANGE}},
      '{OP_INSERT_AT,  32'sd5,          4'd1,  1'b1, '{32'sd0, 5'd0, ST_RANGE}},
      '{OP_INSERT_AT,  32'sd0,          4'd0,  1'b1, '{32'sd0, 5'd1, ST_OK}},
      '{OP_PUSH_BACK,  32'sh7FFF_FFFF,  4'd0,  1'b1, '{32'sd0, 5'd2, ST_OK}},
      '{OP_PUSH_FRONT, 32'sh8000_0000,  4'd0,  1'b1, '{32'sd0, 5'd3, ST_OK}},
      '{OP_READ_AT,    32'sd0,          4'd0,  1'b1, '{32'sh8000_0000, 5'd3, ST_OK}},
      '{OP_READ_AT,    32'sd0,          4'd2,  1'b1, '{32'sh7FFF_FFFF, 5'd3, ST_OK}},
      '{OP_READ_AT,    32'sd0,          4'd3,  1'b1, '{32'sd0, 5'd3, ST_RANGE}},
      '{OP_INSERT_AT,  32'shFFFF_FFFF,  4'd1,  1'b0, '{32'sd0, 5'd0, ST_OK}},
      '{OP_INSERT_AT,  32'sh1234_5678,  4'd4,  1'b0, '{32'sd0, 5'd0, ST_OK}},
      '{OP_INSERT_AT,  32'sd9,          4'd6,  1'b1, '{32'sd0, 5'd5, ST_RANGE}},
      '{OP_REMOVE_AT,  32'sd0,          4'd2,  1'b0, '{32'sd0, 5'd0, ST_OK}},
      '{OP_READ_AT,    32'sd0,          4'd2,  1'b0, '{32'sd0, 5'd0, ST_OK}},
      '{OP_REMOVE_AT,  32'sd0,          4'd15, 1'b1, '{32'sd0, 5'd4, ST_RANGE}},
      '{OP_UNUSED,     32'shFFFF_FFFF,  4'd15, 1'b1, '{32'sd0, 5'd4, ST_OK}},
      '{OP_POP_FRONT,  32'sd0,          4'd0,  1'b0, '{32'sd0, 5'd0, ST_OK}},
      '{OP_READ_AT,    32'sd0,          4'd0,  1'b0, '{32'sd0, 5'd0, ST_OK}},
      '{OP_CLEAR,      32'sd0,          4'd0,  1'b1, '{32'sd0, 5'd0, ST_OK}},
      '{OP_READ_AT,    32'sd0,          4'd0,  1'b1, '{32'sd0, 5'd0, ST_RANGE}},
      '{OP_PUSH_FRONT, 32'shA5A5_A5A5,  4'd0,  1'b0, '{32'sd0, 5'd0, ST_OK}},
      '{OP_REMOVE_AT,  32'sd0,          4'd0,  1'b0, '{32'sd0, 5'd0, ST_OK}}
    };

    // Hold reset, then release it.
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // Random phases until the item budget is used.
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      ph = phase_t'($urandom_range(0, 9) < 4 ? PH_FILL :
                    $urandom_range(0, 9) < 5 ? PH_DRAIN :
                    $urandom_range(0, 9) < 8 ? PH_MIXED : PH_NOISE);
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        row.kind = pick_kind(ph);
        row.value = pick_value();
        row.pos = pick_position(row.kind);
        row.typed = 1'b0;
        row.res = '{32'sd0, 5'd0, ST_OK};
        send_item(row);
      end
    end
    in_valid <= 1'b0;

    // Drain the scoreboard, then allow the pipeline to settle.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d items through the list: %0d full and %0d range responses,",
             items_sent, full_seen, range_seen);
    $display("peak fill %0d of %0d, with random idle on both channels.", peak_fill, CAP);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Run timed out with %0d results outstanding.", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bil_pkg.sv
rtl/core/bil_cell.sv
rtl/core/bounded_indexed_list.sv
dv/tb.sv
